>>> rtl/btse_pkg.sv
// ----------------------------------------------------------------------------
// btse_pkg
// Shared constants, codes and types of the byte trigram set extractor.
// ----------------------------------------------------------------------------
package btse_pkg;

    localparam int WINDOW_BYTES = 3;
    localparam int GRAM_W       = 8 * WINDOW_BYTES;
    localparam int TRIGRAM_W    = 24;
    localparam int COUNT_W      = 25;
    localparam int STATUS_W     = 2;

    // presence store: one row of eight bits per gram with its low three bits dropped
    localparam int ROW_BITS = 8;
    localparam int ADDR_W   = TRIGRAM_W - 3;
    localparam int EPOCH_W  = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 2);

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_EOF     = 2'd1;
    localparam logic [1:0] OP_ABANDON = 2'd2;

    localparam logic [STATUS_W-1:0] FS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] FS_BINARY    = 2'd1;
    localparam logic [STATUS_W-1:0] FS_LARGE     = 2'd2;
    localparam logic [STATUS_W-1:0] FS_ABANDONED = 2'd3;

    localparam logic KIND_GRAM    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(200000);

    typedef enum logic [1:0] {
        PK_GRAM,
        PK_ZERO,
        PK_EOF,
        PK_ABANDON
    } pipe_kind_t;

    typedef struct packed {
        logic                 valid;
        pipe_kind_t           kind;
        logic [TRIGRAM_W-1:0] gram;
    } pipe_t;

    typedef struct packed {
        logic [EPOCH_W-1:0]  tag;
        logic [ROW_BITS-1:0] bits;
    } row_t;

    typedef struct packed {
        logic                 kind;
        logic [TRIGRAM_W-1:0] trigram;
        logic [STATUS_W-1:0]  file_status;
        logic [COUNT_W-1:0]   distinct_total;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic wrap_close;
    } lk_status_t;

endpackage

>>> rtl/btse_presence_ram.sv
// ----------------------------------------------------------------------------
// btse_presence_ram
// Presence store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btse_presence_ram
    import btse_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  row_t              wr_row,
    input  logic [ADDR_W-1:0] rd_addr,
    output row_t              rd_row
);

    row_t mem [2**ADDR_W];

    // read during write returns the old row; the lookup stage forwards
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        rd_row <= mem[rd_addr];
    end

endmodule

>>> rtl/btse_lookup.sv
// ----------------------------------------------------------------------------
// btse_lookup
// Presence check and update, file counters, epoch tags and clearing pass.
// ----------------------------------------------------------------------------
module btse_lookup
    import btse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pipe_t              pipe,
    input  row_t               rd_row,
    input  logic [COUNT_W-1:0] limit,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output row_t               wr_row,
    output logic               res_valid,
    output result_t            res,
    output lk_status_t         status
);

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [STATUS_W-1:0] flag_reg, flag_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic                clearing_reg, clearing_next;
    logic [ADDR_W-1:0]   clear_addr_reg, clear_addr_next;
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    row_t                fwd_row_reg;

    logic [ADDR_W-1:0]   addr;
    row_t                cur_row;
    logic [ROW_BITS-1:0] seen_bits;
    logic [ROW_BITS-1:0] bit_mask;
    logic [COUNT_W-1:0]  count_inc;
    logic                is_new;
    logic                is_close;
    logic                is_abandon;

    always_comb
    begin
        addr       = pipe.gram[TRIGRAM_W-1:3];
        cur_row    = (fwd_valid_reg && (fwd_addr_reg == addr)) ? fwd_row_reg : rd_row;
        // a row tagged with an older epoch belongs to a closed file
        seen_bits  = (cur_row.tag == epoch_reg) ? cur_row.bits : '0;
        bit_mask   = ROW_BITS'(1) << pipe.gram[2:0];
        count_inc  = count_reg + COUNT_W'(1);
        is_new     = pipe.valid && (pipe.kind == PK_GRAM) && (flag_reg == FS_OK)
                     && ((seen_bits & bit_mask) == '0);
        is_abandon = pipe.valid && (pipe.kind == PK_ABANDON);
        is_close   = is_abandon || (pipe.valid && (pipe.kind == PK_EOF));

        count_next      = count_reg;
        flag_next       = flag_reg;
        epoch_next      = epoch_reg;
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = addr;
        wr_row.tag      = epoch_reg;
        wr_row.bits     = seen_bits | bit_mask;

        priority if (clearing_reg)
        begin
            wr_en           = 1'b1;
            wr_addr         = clear_addr_reg;
            wr_row          = '0;
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
            if (&clear_addr_reg)
            begin
                clearing_next = 1'b0;
                epoch_next    = EPOCH_FIRST;
            end
        end
        else if (is_new)
        begin
            wr_en      = 1'b1;
            count_next = count_inc;
            if (count_inc >= limit)
            begin
                flag_next = FS_LARGE;
            end
        end
        else if (pipe.valid && (pipe.kind == PK_ZERO) && (flag_reg == FS_OK))
        begin
            flag_next = FS_BINARY;
        end
        else if (is_close)
        begin
            count_next = '0;
            flag_next  = FS_OK;
            if (epoch_reg == EPOCH_MAX)
            begin
                clearing_next   = 1'b1;
                clear_addr_next = '0;
            end
            else
            begin
                epoch_next = epoch_reg + EPOCH_W'(1);
            end
        end
        else
        begin
        end

        res_valid          = is_new || is_close;
        res.kind           = is_close ? KIND_SUMMARY : KIND_GRAM;
        res.trigram        = is_close ? '0 : pipe.gram;
        res.file_status    = is_abandon ? FS_ABANDONED : (is_close ? flag_reg : FS_OK);
        res.distinct_total = is_close ? count_reg : count_inc;
        res.last           = is_close;

        status.clearing    = clearing_reg;
        status.wrap_close  = is_close && (epoch_reg == EPOCH_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            flag_reg       <= FS_OK;
            epoch_reg      <= '0;
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            flag_reg       <= flag_next;
            epoch_reg      <= epoch_next;
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
            fwd_valid_reg  <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= wr_addr;
        fwd_row_reg  <= wr_row;
    end

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pipe.valid)
        else $error("item reached lookup during clearing pass");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |-> (epoch_reg != '0))
        else $error("epoch zero used outside clearing pass");

    a_wrap_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.wrap_close |=> (clearing_reg && (clear_addr_reg == '0) && (count_reg == '0)))
        else $error("epoch wrap did not start a clearing pass");

    a_marked_no_gram: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_reg != FS_OK) |-> !is_new)
        else $error("gram emitted for a marked file");

endmodule

>>> rtl/btse_out_fifo.sv
// ----------------------------------------------------------------------------
// btse_out_fifo
// Small result queue between the lookup stage and the output stream.
// ----------------------------------------------------------------------------
module btse_out_fifo
    import btse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  result_t               din,
    input  logic                  pop,
    output logic                  nonempty,
    output result_t               dout,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    do_pop;

    assign nonempty = (count_reg != '0);
    assign dout     = slot_reg[rd_ptr_reg];
    assign count    = count_reg;
    assign do_pop   = pop && nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FIFO_CNT_W'(FIFO_DEPTH)) |-> (!push || do_pop))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + FIFO_CNT_W'(1)))
        else $error("result queue count did not follow a push");

endmodule

>>> rtl/byte_trigram_set_extractor_top.sv
// ----------------------------------------------------------------------------
// byte_trigram_set_extractor_top
// Sliding byte window, presence lookup pipeline and result stream.
// ----------------------------------------------------------------------------
// Takes one word per cycle: a data byte, end of file or abandon. Each new
// trigram of a file is registered into lookup, then queued; every close gives
// a summary word with status and distinct count. Throughput is one word per
// cycle, set by the single read-modify-write of the presence RAM per byte;
// same-row hits on back-to-back bytes are forwarded. s_tready drops while the
// four-word result queue, counting the word in lookup, has no room. The store
// is cleared per file by epoch tags, so no time is spent at a close, except
// that after reset and after every 255th file a clearing pass writes all 2^21
// rows of the RAM, during which s_tready is low (configuration writes are
// still taken).
// ----------------------------------------------------------------------------
module byte_trigram_set_extractor_top
    import btse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration: distinct_limit
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // byte_value[7:0]
    input  logic [1:0]         s_tuser,   // operation[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // trigram[23:0], file_status[25:24],
                                          // distinct_total[50:26], zero pad
    output logic [0:0]         m_tuser,   // kind[0]
    output logic               m_tlast
);

    localparam logic [1:0] WB = 2'(WINDOW_BYTES);

    logic [COUNT_W-1:0]    limit_reg;
    logic [GRAM_W-1:0]     window_reg, window_next;
    logic [1:0]            seen_reg, seen_next;
    logic                  bin_reg, bin_next;
    pipe_t                 pipe_reg, pipe_next;

    logic                  accept;
    logic [GRAM_W-1:0]     window_shift;
    logic [1:0]            seen_inc;
    logic [TRIGRAM_W-1:0]  gram_shift;

    row_t                  rd_row;
    row_t                  wr_row;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  res_valid;
    result_t               res;
    lk_status_t            lk_status;
    result_t               q_dout;
    logic [FIFO_CNT_W-1:0] q_count;
    logic [FIFO_CNT_W-1:0] q_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // room for this word and the one still in lookup
    assign q_load   = q_count + FIFO_CNT_W'(pipe_reg.valid);
    assign s_tready = !lk_status.clearing && !lk_status.wrap_close
                      && (q_load <= FIFO_CNT_W'(FIFO_DEPTH - 1));
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        window_shift = {window_reg[GRAM_W-9:0], s_tdata};
        seen_inc     = (seen_reg < WB) ? seen_reg + 2'd1 : seen_reg;
        gram_shift   = TRIGRAM_W'(window_shift);

        window_next    = window_reg;
        seen_next      = seen_reg;
        bin_next       = bin_reg;
        pipe_next.valid = 1'b0;
        pipe_next.kind  = PK_GRAM;
        pipe_next.gram  = gram_shift;

        if (accept)
        begin
            unique case (s_tuser)
                OP_DATA:
                begin
                    if (!bin_reg)
                    begin
                        if (s_tdata == 8'd0)
                        begin
                            bin_next        = 1'b1;
                            pipe_next.valid = 1'b1;
                            pipe_next.kind  = PK_ZERO;
                        end
                        else
                        begin
                            window_next     = window_shift;
                            seen_next       = seen_inc;
                            pipe_next.valid = (seen_inc == WB);
                        end
                    end
                end
                OP_EOF, OP_ABANDON:
                begin
                    window_next     = '0;
                    seen_next       = '0;
                    bin_next        = 1'b0;
                    pipe_next.valid = 1'b1;
                    pipe_next.kind  = (s_tuser == OP_EOF) ? PK_EOF : PK_ABANDON;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
            bin_reg    <= 1'b0;
            pipe_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
            bin_reg    <= bin_next;
            pipe_reg   <= pipe_next;
        end
    end

    btse_presence_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_row  (wr_row),
        .rd_addr (gram_shift[TRIGRAM_W-1:3]),
        .rd_row  (rd_row)
    );

    btse_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .pipe      (pipe_reg),
        .rd_row    (rd_row),
        .limit     (limit_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_row    (wr_row),
        .res_valid (res_valid),
        .res       (res),
        .status    (lk_status)
    );

    btse_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .din      (res),
        .pop      (m_tready),
        .nonempty (m_tvalid),
        .dout     (q_dout),
        .count    (q_count)
    );

    assign m_tdata = {5'd0, q_dout.distinct_total, q_dout.file_status, q_dout.trigram};
    assign m_tuser = q_dout.kind;
    assign m_tlast = q_dout.last;

endmodule

>>> tb/sv/tb_byte_trigram_set_extractor_top.sv
// ----------------------------------------------------------------------------
// tb_byte_trigram_set_extractor_top
// Self-checking bench for the byte trigram set extractor.
// ----------------------------------------------------------------------------
// Builds a list of files (data bytes closed by end of file or abandon), with
// directed cases first and random files after. A clocked driver presents the
// words with random gaps. A trigram predictor runs on every accepted word and
// queues the expected output words. A clocked monitor stalls at random and
// compares each output word field by field with the oldest queued entry.
// The distinct limit is rewritten between phases, only once the block has
// drained.
// ----------------------------------------------------------------------------
module tb_byte_trigram_set_extractor_top;
    import btse_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int DRAIN_SETTLE = 16;
    localparam int HOLD_AFTER = 40;
    localparam int HOLD_CYCLES = 300;
    // sized for the clearing sweep after reset (and after a wrap of the file tags)
    localparam int unsigned WATCHDOG_LIMIT = 4 * (1 << ADDR_W);
    localparam logic [TRIGRAM_W-1:0] GRAM_MASK = TRIGRAM_W'((64'd1 << GRAM_W) - 1);
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS = 66;

    typedef enum logic [1:0] {
        ITEM_WORD,
        ITEM_DRAIN,
        ITEM_LIMIT
    } stim_kind_t;

    typedef struct {
        stim_kind_t         kind;
        logic [1:0]         op;
        logic [7:0]         byte_v;
        int                 gap;
        logic [COUNT_W-1:0] limit;
    } stim_item_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic [1:0]         s_tuser = OP_DATA;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [55:0]        m_tdata;
    logic [0:0]         m_tuser;
    logic               m_tlast;

    // predictor state
    logic [TRIGRAM_W-1:0] gram_window = '0;
    int                   window_fill = 0;
    logic [COUNT_W-1:0]   distinct_seen = '0;
    logic [STATUS_W-1:0]  mark_state = FS_OK;
    logic [COUNT_W-1:0]   limit_model = LIMIT_RESET;
    bit                   gram_seen [bit [TRIGRAM_W-1:0]];

    stim_item_t  pending_words [$];
    result_t     expected_words [$];

    int          fault_count = 0;
    int          stim_words = 0;
    int          send_calm = 0;
    int          recv_calm = 0;
    int          send_wait = 0;
    int          settle = 0;
    int          recv_wait = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          results_seen = 0;
    int unsigned idle_cycles = 0;

    logic        drv_valid;
    logic        drv_cfg;
    logic        mon_ready;
    stim_item_t  head;
    result_t     want;

    byte_trigram_set_extractor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_fault(input string msg);
        $display("MISMATCH: %s", msg);
        fault_count++;
    endtask

    // random number of idle cycles, with occasional runs of back-to-back words
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    task automatic close_file_model();
        gram_seen.delete();
        gram_window = '0;
        window_fill = 0;
        distinct_seen = '0;
        mark_state = FS_OK;
    endtask

    task automatic predict_word(input logic [1:0] op, input logic [7:0] byte_v);
        result_t r;
        if (op == OP_EOF || op == OP_ABANDON)
        begin
            r.kind = KIND_SUMMARY;
            r.trigram = '0;
            r.file_status = (op == OP_ABANDON) ? FS_ABANDONED : mark_state;
            r.distinct_total = distinct_seen;
            r.last = 1'b1;
            expected_words = {expected_words, r};
            close_file_model();
        end
        else if (op == OP_DATA && mark_state == FS_OK)
        begin
            if (byte_v == 8'd0)
                mark_state = FS_BINARY;
            else
            begin
                gram_window = {gram_window[TRIGRAM_W-9:0], byte_v} & GRAM_MASK;
                if (window_fill < WINDOW_BYTES)
                    window_fill++;
                if (window_fill == WINDOW_BYTES && !gram_seen.exists(gram_window))
                begin
                    gram_seen[gram_window] = 1'b1;
                    distinct_seen = distinct_seen + 1'b1;
                    r.kind = KIND_GRAM;
                    r.trigram = gram_window;
                    r.file_status = FS_OK;
                    r.distinct_total = distinct_seen;
                    r.last = 1'b0;
                    expected_words = {expected_words, r};
                    if (distinct_seen >= limit_model)
                        mark_state = FS_LARGE;
                end
            end
        end
    endtask

    task automatic add_word(input logic [1:0] op, input logic [7:0] byte_v);
        stim_item_t it;
        it.kind = ITEM_WORD;
        it.op = op;
        it.byte_v = byte_v;
        it.gap = draw_gap(send_calm);
        it.limit = '0;
        pending_words = {pending_words, it};
        if (op != OP_IGNORED)
            stim_words++;
    endtask

    task automatic add_pause(input stim_kind_t kind, input logic [COUNT_W-1:0] limit);
        stim_item_t it;
        it.kind = kind;
        it.op = OP_DATA;
        it.byte_v = '0;
        it.gap = 0;
        it.limit = limit;
        pending_words = {pending_words, it};
    endtask

    task automatic add_bytes(input logic [7:0] bytes [$], input logic [1:0] close_op);
        foreach (bytes[i])
            add_word(OP_DATA, bytes[i]);
        add_word(close_op, 8'($urandom));
    endtask

    // mostly well-formed files; some short, some long, some binary, a little noise
    task automatic add_random_file();
        int len;
        int sel;
        int alpha_mode;
        logic [7:0] alpha [3];
        logic [7:0] b;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            len = $urandom_range(0, 2);
        else if (sel == 9)
            len = $urandom_range(30, 60);
        else
            len = $urandom_range(3, 24);
        alpha_mode = $urandom_range(0, 1);
        foreach (alpha[i])
            alpha[i] = 8'($urandom_range(1, 255));
        for (int i = 0; i < len; i++)
        begin
            sel = $urandom_range(0, 63);
            if (sel == 0)
                add_word(OP_IGNORED, 8'($urandom));
            if (sel == 1)
                b = 8'd0;
            else if (alpha_mode == 1)
                b = alpha[$urandom_range(0, 2)];
            else
                b = 8'($urandom_range(1, 255));
            add_word(OP_DATA, b);
        end
        if ($urandom_range(0, 4) == 0)
            add_word(OP_ABANDON, 8'($urandom));
        else
            add_word(OP_EOF, 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // driver: presents queued words, predicts at acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
            send_wait = 0;
            settle = 0;
        end
        else
        begin
            drv_valid = s_tvalid;
            drv_cfg = cfg_valid;
            if (s_tvalid && s_tready)
            begin
                predict_word(s_tuser, s_tdata);
                drv_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_model = cfg_data;
                drv_cfg = 1'b0;
            end
            if (!drv_valid && !drv_cfg && pending_words.size() != 0)
            begin
                head = pending_words[0];
                if (head.kind == ITEM_WORD)
                begin
                    if (send_wait < head.gap)
                        send_wait++;
                    else
                    begin
                        send_wait = 0;
                        void'(pending_words.pop_front());
                        drv_valid = 1'b1;
                        s_tdata <= head.byte_v;
                        s_tuser <= head.op;
                    end
                end
                else if (expected_words.size() != 0)
                    settle = 0;
                else if (settle < DRAIN_SETTLE)
                    settle++;   // bytes with no result may still be in flight
                else
                begin
                    settle = 0;
                    void'(pending_words.pop_front());
                    if (head.kind == ITEM_LIMIT)
                    begin
                        drv_cfg = 1'b1;
                        cfg_data <= head.limit;
                    end
                end
            end
            s_tvalid <= drv_valid;
            cfg_valid <= drv_cfg;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random stalls, one long hold-off, field compare
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            mon_ready = m_tready;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                    report_fault($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
                                           m_tdata, m_tuser, m_tlast));
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tuser[0] !== want.kind)
                        report_fault($sformatf("kind got %b want %b", m_tuser[0], want.kind));
                    if (m_tdata[23:0] !== want.trigram)
                        report_fault($sformatf("trigram got %h want %h",
                                               m_tdata[23:0], want.trigram));
                    if (m_tdata[25:24] !== want.file_status)
                        report_fault($sformatf("file_status got %0d want %0d",
                                               m_tdata[25:24], want.file_status));
                    if (m_tdata[50:26] !== want.distinct_total)
                        report_fault($sformatf("distinct_total got %0d want %0d",
                                               m_tdata[50:26], want.distinct_total));
                    if (m_tlast !== want.last)
                        report_fault($sformatf("last got %b want %b", m_tlast, want.last));
                end
                recv_wait = draw_gap(recv_calm);
                if (recv_wait != 0)
                    mon_ready = 1'b0;
            end
            // long stall while the sender keeps offering, so the input backs up
            if (!hold_done && results_seen >= HOLD_AFTER && s_tvalid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                mon_ready = 1'b0;
            end
            else if (!mon_ready)
            begin
                if (recv_wait != 0)
                    recv_wait--;
                else
                    mon_ready = 1'b1;
            end
            m_tready <= mon_ready;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("byte_trigram_set_extractor_top verification failed");
        $finish;
    end

    initial
    begin
        logic [COUNT_W-1:0] phase_limits [RANDOM_PHASES];
        int phase_end;

        // directed: repeats, short file, binary with trailing noise, empty file
        add_bytes('{8'h01, 8'hFF, 8'h80, 8'h01, 8'hFF, 8'h80}, OP_EOF);
        add_bytes('{8'h41, 8'h42}, OP_ABANDON);
        add_word(OP_DATA, 8'h41);
        add_word(OP_DATA, 8'h42);
        add_word(OP_DATA, 8'h43);
        add_word(OP_DATA, 8'h00);
        add_word(OP_DATA, 8'h44);
        add_word(OP_IGNORED, 8'hFF);
        add_word(OP_EOF, 8'h00);
        add_word(OP_IGNORED, 8'h00);
        add_word(OP_EOF, 8'hFF);
        // limit one: first trigram goes out, the rest are dropped
        add_pause(ITEM_LIMIT, COUNT_W'(1));
        add_bytes('{8'h10, 8'h20, 8'h30, 8'h40}, OP_EOF);
        // limit zero behaves as one
        add_pause(ITEM_LIMIT, COUNT_W'(0));
        add_bytes('{8'hFE, 8'h7F, 8'h01}, OP_EOF);

        phase_limits = '{COUNT_W'(4), COUNT_W'(1), COUNT_W'(33554431), COUNT_W'(2),
                         COUNT_W'(16777216), COUNT_W'($urandom_range(5, 30)),
                         COUNT_W'(0), LIMIT_RESET};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            add_pause(ITEM_LIMIT, phase_limits[p]);
            phase_end = stim_words + PHASE_WORDS;
            while (stim_words < phase_end)
            begin
                add_random_file();
                if (p == 2 && stim_words > phase_end - PHASE_WORDS / 2
                    && pending_words[$].kind == ITEM_WORD && $urandom_range(0, 3) == 0)
                    add_pause(ITEM_DRAIN, '0);
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pending_words.size() != 0 || s_tvalid || cfg_valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
        if (expected_words.size() != 0)
            report_fault($sformatf("%0d expected words never arrived", expected_words.size()));

        if (fault_count == 0)
            $display("byte_trigram_set_extractor_top verification clean");
        else
            $display("byte_trigram_set_extractor_top verification failed");
        $finish;
    end

endmodule
